[design/pcbp_pkg.sv]
package pcbp_pkg;

    localparam int POS_BITS_DEF = 16;

    typedef enum logic [2:0] {
        MODE_TICK      = 3'd0,
        MODE_SET_GOAL  = 3'd1,
        MODE_SET_MOT   = 3'd2,
        MODE_MARK_DOWN = 3'd3,
        MODE_MARK_UP   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        MOT_STOP = 2'd0,
        MOT_INC  = 2'd1,
        MOT_DEC  = 2'd2
    } motion_t;

    typedef enum logic [1:0] {
        CAL_NONE = 2'd0,
        CAL_DOWN = 2'd1,
        CAL_UP   = 2'd2
    } cal_t;

endpackage

[design/pulse_count_blind_positioner.sv]
// Blind motor positioner with pulse counting.
// Input channel s_*: one transaction per tick or command. s_tuser carries the
// kind (tick, set target, set motion, mark bottom, mark top), s_tdata the
// sensor sample, requested target and manual motion.
// Output channel m_*: exactly one result per input transaction, in order,
// with the drive pins, motion state, counted position, stored target,
// calibrated maximum and the change-event flags of that transaction.
// The result appears on m_tvalid in the cycle after the input transaction.
// Throughput is one transaction per cycle while m_tready holds; the state
// registers and the single output register are the only storage, so the
// next item sees the state left by the previous one without any bubble.
// When the receiver stalls, the result waits in the output register and
// s_tready drops until it is taken; s_tready is high whenever the output
// register is empty or being emptied in the same cycle.
// Reset (rst_n low, asynchronous) stops the motor, clears position, target,
// maximum and the sensor history, and empties the output register.
module pulse_count_blind_positioner #(
    parameter int POS_BITS = pcbp_pkg::POS_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // sense, target, motion (lowest bit down), zero padded
    input  logic [((POS_BITS + 3 + 7) / 8) * 8 - 1:0] s_tdata,
    // mode
    input  logic [2:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // up_drive, down_drive, motion_state, position, goal, goal_valid,
    // max_position, moving, ev_state, ev_position, ev_target, ev_calibrate
    output logic [((3 * POS_BITS + 11 + 7) / 8) * 8 - 1:0] m_tdata
);
    import pcbp_pkg::*;

    localparam int IN_W  = ((POS_BITS + 3 + 7) / 8) * 8;
    localparam int RES_W = 3 * POS_BITS + 11;
    localparam int OUT_W = ((RES_W + 7) / 8) * 8;
    localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

    function automatic logic signed [POS_BITS-1:0] sat_sub(
        input logic signed [POS_BITS-1:0] a,
        input logic signed [POS_BITS-1:0] b
    );
        logic signed [POS_BITS:0] d;
        d = {a[POS_BITS-1], a} - {b[POS_BITS-1], b};
        if (d[POS_BITS] != d[POS_BITS-1])
            sat_sub = d[POS_BITS] ? POS_MIN : POS_MAX;
        else
            sat_sub = d[POS_BITS-1:0];
    endfunction

    // input fields
    logic                       in_sense;
    logic signed [POS_BITS-1:0] in_target;
    logic [1:0]                 in_motion;
    motion_t                    mot_in;

    // state
    motion_t                    motion_reg, motion_next;
    logic                       last_sense_reg, last_sense_next;
    logic signed [POS_BITS-1:0] position_reg, position_next;
    logic signed [POS_BITS-1:0] goal_reg, goal_next;
    logic                       goal_valid_reg, goal_valid_next;
    logic signed [POS_BITS-1:0] max_reg, max_next;
    logic signed [POS_BITS-1:0] step_pos;

    logic moving, ev_state, ev_position, ev_target;
    cal_t ev_cal;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [RES_W-1:0]  result;
    logic              accept;

    assign in_sense  = s_tdata[0];
    assign in_target = s_tdata[POS_BITS:1];
    assign in_motion = s_tdata[POS_BITS+2:POS_BITS+1];

    // motion code three means stopped
    always_comb
    begin
        if (in_motion == MOT_INC)
            mot_in = MOT_INC;
        else if (in_motion == MOT_DEC)
            mot_in = MOT_DEC;
        else
            mot_in = MOT_STOP;
    end

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        motion_next     = motion_reg;
        last_sense_next = last_sense_reg;
        position_next   = position_reg;
        goal_next       = goal_reg;
        goal_valid_next = goal_valid_reg;
        max_next        = max_reg;
        step_pos        = position_reg;
        moving          = 1'b0;
        ev_state        = 1'b0;
        ev_position     = 1'b0;
        ev_target       = 1'b0;
        ev_cal          = CAL_NONE;

        unique case (mode_t'(s_tuser))
            MODE_TICK:
            begin
                if (motion_reg != MOT_STOP)
                begin
                    moving = 1'b1;
                    if (in_sense != last_sense_reg)
                    begin
                        last_sense_next = in_sense;
                        if (motion_reg == MOT_DEC && position_reg != POS_MIN)
                            step_pos = position_reg - 1'b1;
                        else if (motion_reg == MOT_INC && position_reg != POS_MAX)
                            step_pos = position_reg + 1'b1;
                    end
                    ev_position   = (step_pos != position_reg);
                    position_next = step_pos;
                    // stop once the target is reached or passed
                    if (goal_valid_reg &&
                        ((motion_reg == MOT_INC && step_pos >= goal_reg) ||
                         (motion_reg == MOT_DEC && step_pos <= goal_reg)))
                    begin
                        motion_next = MOT_STOP;
                        ev_state    = 1'b1;
                    end
                end
            end
            MODE_SET_GOAL:
            begin
                goal_next       = in_target;
                goal_valid_next = 1'b1;
                ev_target       = 1'b1;
                if (in_target > position_reg)
                begin
                    motion_next = MOT_INC;
                    ev_state    = 1'b1;
                end
                else if (in_target < position_reg)
                begin
                    motion_next = MOT_DEC;
                    ev_state    = 1'b1;
                end
            end
            MODE_SET_MOT:
            begin
                goal_valid_next = 1'b0;
                goal_next       = '0;
                if (motion_reg != mot_in)
                begin
                    motion_next = mot_in;
                    ev_state    = 1'b1;
                end
            end
            MODE_MARK_DOWN:
            begin
                max_next = position_reg;
                ev_cal   = CAL_DOWN;
            end
            MODE_MARK_UP:
            begin
                // rebase to zero at the top
                max_next = sat_sub(max_reg, position_reg);
                if (goal_valid_reg)
                    goal_next = sat_sub(goal_reg, position_reg);
                ev_position   = (position_reg != '0);
                position_next = '0;
                ev_cal        = CAL_UP;
            end
            default:
            begin
            end
        endcase
    end

    assign result = {
        ev_cal,
        ev_target,
        ev_position,
        ev_state,
        moving,
        max_next,
        goal_valid_next,
        (goal_valid_next ? goal_next : {POS_BITS{1'b0}}),
        position_next,
        motion_next,
        (motion_next == MOT_INC),
        (motion_next == MOT_DEC)
    };

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (s_tready)
            m_tvalid_next = s_tvalid;
        if (accept)
            m_tdata_next = {{(OUT_W - RES_W){1'b0}}, result};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_reg     <= MOT_STOP;
            last_sense_reg <= 1'b0;
            position_reg   <= '0;
            goal_reg       <= '0;
            goal_valid_reg <= 1'b0;
            max_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (accept)
            begin
                motion_reg     <= motion_next;
                last_sense_reg <= last_sense_next;
                position_reg   <= position_next;
                goal_reg       <= goal_next;
                goal_valid_reg <= goal_valid_next;
                max_reg        <= max_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // IN_W repeats the input port width and bounds the unused-bit fold
    logic unused_pad;
    assign unused_pad = ^s_tdata[IN_W-1:POS_BITS+1];

endmodule

[design/pcbp_checker.sv]
module pcbp_checker #(
    parameter int POS_BITS = pcbp_pkg::POS_BITS_DEF
) (
    input logic                                        clk,
    input logic                                        rst_n,
    input logic                                        s_tvalid,
    input logic                                        s_tready,
    input logic                                        m_tvalid,
    input logic                                        m_tready,
    input logic [((3 * POS_BITS + 11 + 7) / 8) * 8 - 1:0] m_tdata
);
    import pcbp_pkg::*;

    localparam int GOAL_LO = 4 + POS_BITS;
    localparam int GV_BIT  = 4 + 2 * POS_BITS;
    localparam int EVT_BIT = 8 + 3 * POS_BITS;

    logic                up_drive, down_drive, goal_valid, ev_target;
    logic [1:0]          motion_state;
    logic [POS_BITS-1:0] goal;

    assign up_drive     = m_tdata[0];
    assign down_drive   = m_tdata[1];
    assign motion_state = m_tdata[3:2];
    assign goal         = m_tdata[GOAL_LO+POS_BITS-1:GOAL_LO];
    assign goal_valid   = m_tdata[GV_BIT];
    assign ev_target    = m_tdata[EVT_BIT];

    // every accepted item yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after accepted transaction");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_drive_pins: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(up_drive && down_drive) &&
                     (up_drive == (motion_state == MOT_DEC)) &&
                     (down_drive == (motion_state == MOT_INC)))
        else $error("drive pins disagree with motion state");

    a_target_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ev_target |-> goal_valid)
        else $error("target event without valid target");

    a_goal_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !goal_valid |-> goal == '0)
        else $error("goal nonzero in manual mode");

endmodule

bind pulse_count_blind_positioner pcbp_checker #(.POS_BITS(POS_BITS)) u_pcbp_checker (.*);

[verif/tb_pulse_count_blind_positioner.sv]
`timescale 1ns / 1ps

module tb_pulse_count_blind_positioner;

    import pcbp_pkg::*;

    localparam int PB          = POS_BITS_DEF;
    localparam int SD_W        = ((PB + 3 + 7) / 8) * 8;
    localparam int MD_W        = ((3 * PB + 11 + 7) / 8) * 8;
    localparam int POS_HI      = (1 << (PB - 1)) - 1;
    localparam int POS_LO      = -POS_HI - 1;
    localparam int CYCLE_LIMIT = 600000;

    // motion code with no meaning of its own, the block takes it as stopped
    localparam logic [1:0] MOT_UNUSED = 2'd3;

    // one result, last field in the lowest bits so it maps straight onto m_tdata
    typedef struct packed {
        logic [MD_W-3*PB-12:0] pad;
        logic [1:0]            ev_calibrate;
        logic                  ev_target;
        logic                  ev_position;
        logic                  ev_state;
        logic                  moving;
        logic [PB-1:0]         max_position;
        logic                  goal_valid;
        logic [PB-1:0]         goal;
        logic [PB-1:0]         position;
        logic [1:0]            motion_state;
        logic                  down_drive;
        logic                  up_drive;
    } blind_status_t;

    logic            clk      = 1'b0;
    logic            rst_n    = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    // sense, target, motion (lowest bit down), zero padded
    logic [SD_W-1:0] s_tdata  = '0;
    // mode
    logic [2:0]      s_tuser  = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    // up_drive, down_drive, motion_state, position, goal, goal_valid,
    // max_position, moving, ev_state, ev_position, ev_target, ev_calibrate
    logic [MD_W-1:0] m_tdata;

    // shadow state of the positioner
    motion_t pr_motion;
    logic    pr_last_sense;
    int      pr_pos;
    int      pr_goal;
    int      pr_max;
    logic    pr_goal_valid;

    blind_status_t expected_status_q[$];

    int n_fail        = 0;
    int n_effective   = 0;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int cycle_cnt     = 0;

    pulse_count_blind_positioner #(
        .POS_BITS (PB)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= rst_n && ($urandom_range(0, 99) >= snk_stall_pct);
    end

    function automatic int clamp_pos(input int v);
        if (v > POS_HI)
            return POS_HI;
        if (v < POS_LO)
            return POS_LO;
        return v;
    endfunction

    function automatic blind_status_t step_blind(input logic [2:0] mode, input logic sense,
                                                 input logic signed [PB-1:0] tgt,
                                                 input logic [1:0] mot);
        blind_status_t r;
        motion_t       req;
        int            np;
        r   = '0;
        req = (mot > MOT_DEC) ? MOT_STOP : motion_t'(mot);
        case (mode)
            MODE_TICK:
            begin
                if (pr_motion != MOT_STOP)
                begin
                    r.moving = 1'b1;
                    if (sense != pr_last_sense)
                    begin
                        pr_last_sense = sense;
                        np = clamp_pos(pr_pos + ((pr_motion == MOT_INC) ? 1 : -1));
                        r.ev_position = (np != pr_pos);
                        pr_pos = np;
                    end
                    if (pr_goal_valid && ((pr_motion == MOT_INC && pr_pos >= pr_goal) ||
                                          (pr_motion == MOT_DEC && pr_pos <= pr_goal)))
                    begin
                        pr_motion  = MOT_STOP;
                        r.ev_state = 1'b1;
                    end
                end
            end
            MODE_SET_GOAL:
            begin
                pr_goal       = clamp_pos(int'(tgt));
                pr_goal_valid = 1'b1;
                r.ev_target   = 1'b1;
                if (pr_goal > pr_pos)
                begin
                    pr_motion  = MOT_INC;
                    r.ev_state = 1'b1;
                end
                else if (pr_goal < pr_pos)
                begin
                    pr_motion  = MOT_DEC;
                    r.ev_state = 1'b1;
                end
            end
            MODE_SET_MOT:
            begin
                pr_goal_valid = 1'b0;
                pr_goal       = 0;
                if (pr_motion != req)
                begin
                    pr_motion  = req;
                    r.ev_state = 1'b1;
                end
            end
            MODE_MARK_DOWN:
            begin
                pr_max         = pr_pos;
                r.ev_calibrate = CAL_DOWN;
            end
            MODE_MARK_UP:
            begin
                pr_max = clamp_pos(pr_max - pr_pos);
                if (pr_goal_valid)
                    pr_goal = clamp_pos(pr_goal - pr_pos);
                r.ev_position  = (pr_pos != 0);
                pr_pos         = 0;
                r.ev_calibrate = CAL_UP;
            end
            default:
            begin
            end
        endcase
        r.up_drive     = (pr_motion == MOT_DEC);
        r.down_drive   = (pr_motion == MOT_INC);
        r.motion_state = pr_motion;
        r.position     = pr_pos[PB-1:0];
        r.goal         = pr_goal_valid ? pr_goal[PB-1:0] : '0;
        r.goal_valid   = pr_goal_valid;
        r.max_position = pr_max[PB-1:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [PB-1:0] want,
                                        input logic [PB-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        blind_status_t want;
        blind_status_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_status_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
                n_fail++;
            end
            else
            begin
                want = expected_status_q.pop_front();
                check_field("up_drive", want.up_drive, got.up_drive);
                check_field("down_drive", want.down_drive, got.down_drive);
                check_field("motion_state", want.motion_state, got.motion_state);
                check_field("position", want.position, got.position);
                check_field("goal", want.goal, got.goal);
                check_field("goal_valid", want.goal_valid, got.goal_valid);
                check_field("max_position", want.max_position, got.max_position);
                check_field("moving", want.moving, got.moving);
                check_field("ev_state", want.ev_state, got.ev_state);
                check_field("ev_position", want.ev_position, got.ev_position);
                check_field("ev_target", want.ev_target, got.ev_target);
                check_field("ev_calibrate", want.ev_calibrate, got.ev_calibrate);
                check_field("padding", want.pad, got.pad);
            end
        end
    end

    task automatic send_item(input logic [2:0] mode, input logic sense,
                             input logic [PB-1:0] tgt, input logic [1:0] mot);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(SD_W - PB - 3){1'b0}}, mot, tgt, sense};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // transaction taken at this edge
        if (!(mode > MODE_MARK_UP || (mode == MODE_TICK && pr_motion == MOT_STOP)))
            n_effective++;
        expected_status_q.push_back(step_blind(mode, sense, tgt, mot));
    endtask

    // tick that flips the sensor level, other fields are don't-care
    task automatic tick_edge();
        send_item(MODE_TICK, ~pr_last_sense, PB'($urandom), 2'($urandom));
    endtask

    task automatic test_commands();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        // sample while stopped is dropped, sensor history kept
        send_item(MODE_TICK, 1'b1, '1, MOT_INC);
        for (int m = MODE_MARK_UP + 1; m < 8; m++)
            send_item(3'(m), 1'b1, PB'($urandom), 2'($urandom));
        send_item(MODE_SET_MOT, 1'b0, '0, MOT_UNUSED);
        send_item(MODE_SET_MOT, 1'b0, '0, MOT_INC);
        send_item(MODE_SET_MOT, 1'b0, '0, MOT_INC);
        send_item(MODE_TICK, 1'b1, '0, MOT_STOP);
        send_item(MODE_TICK, 1'b1, '0, MOT_STOP);
        send_item(MODE_TICK, 1'b0, '0, MOT_STOP);
        // target equal to position, next tick stops without an edge
        send_item(MODE_SET_GOAL, 1'b0, PB'(pr_pos), MOT_STOP);
        send_item(MODE_TICK, pr_last_sense, '0, MOT_STOP);
        send_item(MODE_SET_GOAL, 1'b1, PB'(POS_HI), MOT_DEC);
        send_item(MODE_MARK_DOWN, 1'b0, '0, MOT_STOP);
        send_item(MODE_SET_GOAL, 1'b0, PB'(POS_LO), MOT_INC);
        tick_edge();
        // target shift saturates low here
        send_item(MODE_MARK_UP, 1'b0, '0, MOT_STOP);
        send_item(MODE_MARK_UP, 1'b1, '1, MOT_UNUSED);
        send_item(MODE_SET_MOT, 1'b0, '0, MOT_STOP);
        send_item(MODE_MARK_UP, 1'b0, '0, MOT_STOP);
        send_item(MODE_SET_MOT, 1'b0, '0, MOT_DEC);
        send_item(MODE_SET_MOT, 1'b0, '0, MOT_UNUSED);
    endtask

    task automatic test_range_ends();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_item(MODE_SET_MOT, 1'b0, '0, MOT_DEC);
        repeat (3) tick_edge();
        // target at the top end, shift on mark top saturates high
        send_item(MODE_SET_GOAL, 1'b0, PB'(POS_HI), MOT_STOP);
        send_item(MODE_MARK_UP, 1'b0, '0, MOT_STOP);
        send_item(MODE_SET_MOT, 1'b0, '0, MOT_INC);
        repeat (2) tick_edge();
        send_item(MODE_SET_GOAL, 1'b0, PB'(POS_LO), MOT_STOP);
        send_item(MODE_MARK_UP, 1'b0, '0, MOT_STOP);
        send_item(MODE_SET_MOT, 1'b0, '0, MOT_STOP);
    endtask

    task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
        int goal_at;
        int delta;
        int kind;
        int n_ticks;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        goal_at = n_effective + n_items;
        while (n_effective < goal_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                // move to a nearby target, mostly clean edges, some repeated samples
                delta = $urandom_range(0, 80);
                send_item(MODE_SET_GOAL, 1'($urandom), PB'(clamp_pos(pr_pos + delta - 40)),
                          2'($urandom));
                n_ticks = 0;
                while (pr_motion != MOT_STOP && n_ticks < 120)
                begin
                    if ($urandom_range(0, 99) < 85)
                        tick_edge();
                    else
                        send_item(MODE_TICK, pr_last_sense, PB'($urandom), 2'($urandom));
                    n_ticks++;
                end
                repeat ($urandom_range(0, 2)) tick_edge();
            end
            else if (kind < 65)
            begin
                send_item(MODE_SET_MOT, 1'($urandom), PB'($urandom), 2'($urandom));
                repeat ($urandom_range(1, 30))
                    send_item(MODE_TICK, 1'($urandom), PB'($urandom), 2'($urandom));
            end
            else if (kind < 75)
            begin
                send_item($urandom_range(0, 1) ? MODE_MARK_UP : MODE_MARK_DOWN,
                          1'($urandom), PB'($urandom), 2'($urandom));
            end
            else if (kind < 90)
            begin
                send_item(3'($urandom), 1'($urandom), PB'($urandom), 2'($urandom));
            end
            else
            begin
                // far target, abandoned after a few edges
                send_item(MODE_SET_GOAL, 1'($urandom), PB'($urandom), 2'($urandom));
                repeat ($urandom_range(1, 8)) tick_edge();
            end
        end
    endtask

    initial
    begin
        pr_motion     = MOT_STOP;
        pr_last_sense = 1'b0;
        pr_pos        = 0;
        pr_goal       = 0;
        pr_max        = 0;
        pr_goal_valid = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_commands();
        test_range_ends();
        test_random(400, 0, 0);
        test_random(400, 61, 0);
        test_random(400, 0, 61);
        test_random(400, 22, 22);
        s_tvalid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (n_fail == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
